// ----- rtl/ggc_pkg.sv -----
// Shared types and constants for the greedy graph coloring block.
// No dependencies.
package ggc_pkg;

    localparam int VERT_W = 6;
    localparam int DEG_W = 8;
    localparam int CLR_W = 7;
    localparam int USED_W = 64;
    localparam logic [DEG_W-1:0] DEG_MAX = 8'd255;

    typedef logic [VERT_W-1:0] vert_t;
    typedef logic [DEG_W-1:0] deg_t;
    typedef logic [CLR_W-1:0] clr_t;

endpackage

// ----- rtl/greedy_graph_coloring.sv -----
// Greedy (Welsh-Powell) graph coloring: edge loading, degree ordering, coloring.
// Depends on ggc_pkg and ggc_ram.
//
//  channel | dir | tdata                               | tlast       | tuser
//  s_axis  | in  | [5:0] first_vertex [11:6] second    | last_edge   | -
//  m_axis  | out | [5:0] vertex [11:6] color           | last_vertex | [0] dropped [1] empty
//
// An edge is a read-modify-write of both adjacency rows and degrees (S_EA, then S_EB);
// a dropped edge only sets the dropped flag in S_IDLE. A run over N vertices repeats
// per vertex: one degree scan, row fetch, one color scan, emit.
// After reset and every run a clearing pass over all MAX_VERTICES rows zeroes adjacency
// and degree stores; no edge is taken meanwhile. A stalled result blocks only the next one.
module greedy_graph_coloring #(
    parameter int MAX_VERTICES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // first_vertex, second_vertex, zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // vertex, color, zero pad
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // edges_dropped, empty_graph
);
    import ggc_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EA    = 4'd2;
    localparam logic [3:0] S_EB    = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_SEL   = 4'd5;
    localparam logic [3:0] S_ROW   = 4'd6;
    localparam logic [3:0] S_COL   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_EMPTY = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [IW-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic last_reg, last_next;
    vert_t highest_reg, highest_next;
    logic drop_reg, drop_next;
    logic [MAX_VERTICES-1:0] wrow_reg, wrow_next;
    deg_t wdeg_reg, wdeg_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic pend_v_reg, pend_v_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic pend_hit_reg, pend_hit_next;
    logic best_v_reg, best_v_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    deg_t best_deg_reg, best_deg_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [MAX_VERTICES-1:0] colored_reg, colored_next;
    logic [CW-1:0] k_reg, k_next;
    logic ov_reg, ov_next;
    vert_t ovtx_reg, ovtx_next, ocol_reg, ocol_next;
    logic olast_reg, olast_next, odrop_reg, odrop_next, oempty_reg, oempty_next;

    logic adj_we, deg_we, clr_we;
    logic [IW-1:0] adj_wa, adj_ra, deg_wa, deg_ra, clr_wa, clr_ra;
    logic [MAX_VERTICES-1:0] adj_wd, adj_rd, base_row;
    deg_t deg_wd, deg_rd, base_deg;
    clr_t clr_wd, clr_rd, new_clr;

    vert_t in_a, in_b;
    logic in_ok, in_xfer, oslot;
    logic [CW-1:0] count_w;

    ggc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
        .raddr(adj_ra), .rdata(adj_rd));
    ggc_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
        .raddr(deg_ra), .rdata(deg_rd));
    ggc_ram #(.WIDTH(CLR_W), .DEPTH(MAX_VERTICES)) u_clr (
        .clk(clk), .we(clr_we), .waddr(clr_wa), .wdata(clr_wd),
        .raddr(clr_ra), .rdata(clr_rd));

    assign in_a = s_axis_tdata[5:0];
    assign in_b = s_axis_tdata[11:6];
    assign in_ok = (in_a != '0) && (in_b != '0)
        && ({1'b0, in_a} <= 7'(MAX_VERTICES)) && ({1'b0, in_b} <= 7'(MAX_VERTICES));
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign oslot = !ov_reg || m_axis_tready;
    assign count_w = CW'(highest_reg);

    // smallest color not held by a colored neighbor
    always_comb
    begin
        new_clr = clr_t'(USED_W);
        for (int j = USED_W - 2; j >= 0; j--)
        begin
            if (!used_reg[j])
            begin
                new_clr = clr_t'(j + 1);
            end
        end
    end

    always_comb
    begin
        base_row = (state_reg == S_EB && ia_reg == ib_reg) ? wrow_reg : adj_rd;
        base_deg = (state_reg == S_EB && ia_reg == ib_reg) ? wdeg_reg : deg_rd;
    end

    always_comb
    begin
        state_next = state_reg;
        ia_next = ia_reg;
        ib_next = ib_reg;
        last_next = last_reg;
        highest_next = highest_reg;
        drop_next = drop_reg;
        wrow_next = wrow_reg;
        wdeg_next = wdeg_reg;
        scan_next = scan_reg;
        pend_v_next = pend_v_reg;
        pend_idx_next = pend_idx_reg;
        pend_hit_next = pend_hit_reg;
        best_v_next = best_v_reg;
        best_idx_next = best_idx_reg;
        best_deg_next = best_deg_reg;
        row_next = row_reg;
        used_next = used_reg;
        colored_next = colored_reg;
        k_next = k_reg;
        ov_next = ov_reg && !m_axis_tready;
        ovtx_next = ovtx_reg;
        ocol_next = ocol_reg;
        olast_next = olast_reg;
        odrop_next = odrop_reg;
        oempty_next = oempty_reg;
        adj_we = 1'b0;
        adj_wa = scan_reg[IW-1:0];
        adj_wd = '0;
        adj_ra = ia_reg;
        deg_we = 1'b0;
        deg_wa = scan_reg[IW-1:0];
        deg_wd = '0;
        deg_ra = ia_reg;
        clr_we = 1'b0;
        clr_wa = best_idx_reg;
        clr_wd = new_clr;
        clr_ra = scan_reg[IW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                adj_we = 1'b1;
                deg_we = 1'b1;
                highest_next = '0;
                drop_next = 1'b0;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == CW'(MAX_VERTICES - 1))
                begin
                    scan_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ia_next = IW'(in_a - 6'd1);
                ib_next = IW'(in_b - 6'd1);
                adj_ra = IW'(in_a - 6'd1);
                deg_ra = IW'(in_a - 6'd1);
                if (in_xfer)
                begin
                    last_next = s_axis_tlast;
                    if (in_ok)
                    begin
                        if (in_a > highest_next)
                        begin
                            highest_next = in_a;
                        end
                        if (in_b > highest_next)
                        begin
                            highest_next = in_b;
                        end
                        state_next = S_EA;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                        state_next = s_axis_tlast ? S_START : S_IDLE;
                    end
                end
            end
            S_EA, S_EB:
            begin
                adj_we = 1'b1;
                deg_we = 1'b1;
                adj_wa = (state_reg == S_EA) ? ia_reg : ib_reg;
                deg_wa = adj_wa;
                adj_wd = base_row | (MAX_VERTICES'(1) << ((state_reg == S_EA) ? ib_reg : ia_reg));
                deg_wd = (base_deg == DEG_MAX) ? base_deg : base_deg + 1'b1;
                wrow_next = adj_wd;
                wdeg_next = deg_wd;
                adj_ra = ib_reg;
                deg_ra = ib_reg;
                if (state_reg == S_EA)
                begin
                    state_next = S_EB;
                end
                else
                begin
                    state_next = last_reg ? S_START : S_IDLE;
                end
            end
            S_START:
            begin
                colored_next = '0;
                k_next = '0;
                scan_next = '0;
                pend_v_next = 1'b0;
                best_v_next = 1'b0;
                state_next = (highest_reg == '0) ? S_EMPTY : S_SEL;
            end
            S_EMPTY:
            begin
                if (oslot)
                begin
                    ov_next = 1'b1;
                    ovtx_next = '0;
                    ocol_next = '0;
                    olast_next = 1'b1;
                    odrop_next = drop_reg;
                    oempty_next = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_SEL:
            begin
                deg_ra = scan_reg[IW-1:0];
                adj_ra = best_idx_reg;
                pend_idx_next = scan_reg[IW-1:0];
                pend_v_next = (scan_reg < count_w);
                if (scan_reg < count_w)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (pend_v_reg && !colored_reg[pend_idx_reg]
                    && (!best_v_reg || deg_rd > best_deg_reg))
                begin
                    best_v_next = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_deg_next = deg_rd;
                end
                if (!pend_v_reg && scan_reg >= count_w)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                row_next = adj_rd & colored_reg;
                used_next = '0;
                scan_next = '0;
                pend_v_next = 1'b0;
                state_next = S_COL;
            end
            S_COL:
            begin
                pend_v_next = (scan_reg < count_w);
                pend_hit_next = row_reg[scan_reg[IW-1:0]];
                if (scan_reg < count_w)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (pend_v_reg && pend_hit_reg && clr_rd != '0)
                begin
                    used_next = used_reg | (USED_W'(1) << (clr_rd - 1'b1));
                end
                if (!pend_v_reg && scan_reg >= count_w)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (oslot)
                begin
                    clr_we = 1'b1;
                    colored_next = colored_reg | (MAX_VERTICES'(1) << best_idx_reg);
                    ov_next = 1'b1;
                    ovtx_next = vert_t'(best_idx_reg) + 1'b1;
                    ocol_next = new_clr[VERT_W-1:0];
                    olast_next = (k_reg + 1'b1 == count_w);
                    odrop_next = drop_reg;
                    oempty_next = 1'b0;
                    k_next = k_reg + 1'b1;
                    scan_next = '0;
                    pend_v_next = 1'b0;
                    best_v_next = 1'b0;
                    state_next = (k_reg + 1'b1 == count_w) ? S_CLEAR : S_SEL;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            scan_reg <= '0;
            highest_reg <= '0;
            drop_reg <= 1'b0;
            ov_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            best_v_reg <= 1'b0;
            colored_reg <= '0;
            k_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg <= scan_next;
            highest_reg <= highest_next;
            drop_reg <= drop_next;
            ov_reg <= ov_next;
            pend_v_reg <= pend_v_next;
            best_v_reg <= best_v_next;
            colored_reg <= colored_next;
            k_reg <= k_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg <= ia_next;
        ib_reg <= ib_next;
        wrow_reg <= wrow_next;
        wdeg_reg <= wdeg_next;
        pend_idx_reg <= pend_idx_next;
        pend_hit_reg <= pend_hit_next;
        best_idx_reg <= best_idx_next;
        best_deg_reg <= best_deg_next;
        row_reg <= row_next;
        used_reg <= used_next;
        ovtx_reg <= ovtx_next;
        ocol_reg <= ocol_next;
        olast_reg <= olast_next;
        odrop_reg <= odrop_next;
        oempty_reg <= oempty_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {4'd0, ocol_reg, ovtx_reg};
    assign m_axis_tlast = olast_reg;
    assign m_axis_tuser = {oempty_reg, odrop_reg};

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && m_axis_tdata[11:0] == 12'd0))
        else $error("empty-graph result malformed");
    a_valid_edge_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ok) |=> (state_reg == S_EA) ##1 (state_reg == S_EB))
        else $error("edge update sequence broken");
    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && oslot && k_reg + 1'b1 == count_w) |=> (state_reg == S_CLEAR))
        else $error("run did not end in clearing pass");
endmodule

// ----- rtl/ggc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- tb/ggc_checker.sv -----
// Checker for greedy_graph_coloring: watches both stream channels, predicts results.
// Depends on ggc_pkg; instantiated by tb_top beside the block.
module ggc_checker #(
    parameter int MAX_VERTICES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending
);
    import ggc_pkg::*;

    typedef struct packed {
        logic [5:0] vertex;
        logic [5:0] color;
        logic       last_vertex;
        logic       dropped;
        logic       empty;
    } coloring_t;

    logic [63:0] adj_rows [MAX_VERTICES];
    deg_t        degree [MAX_VERTICES];
    logic [5:0]  color_of [MAX_VERTICES];
    int          order [MAX_VERTICES];
    int          top_vertex;
    logic        dropped_seen;
    coloring_t   expected_colors [$];

    assign pending = expected_colors.size();

    function automatic void clear_graph();
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            adj_rows[i] = '0;
            degree[i] = '0;
        end
        top_vertex = 0;
        dropped_seen = 1'b0;
    endfunction

    function automatic void take_edge(int a, int b, bit last);
        int key;
        int j;
        int v;
        int c;
        logic [63:0] used;
        logic [63:0] colored;
        coloring_t r;
        if (a == 0 || b == 0 || a > MAX_VERTICES || b > MAX_VERTICES)
            dropped_seen = 1'b1;
        else
        begin
            adj_rows[a-1][b-1] = 1'b1;
            adj_rows[b-1][a-1] = 1'b1;
            if (degree[a-1] != DEG_MAX) degree[a-1]++;
            if (degree[b-1] != DEG_MAX) degree[b-1]++;
            if (a > top_vertex) top_vertex = a;
            if (b > top_vertex) top_vertex = b;
        end
        if (!last) return;
        if (top_vertex == 0)
        begin
            r = '{vertex: 0, color: 0, last_vertex: 1, dropped: dropped_seen, empty: 1};
            expected_colors.push_back(r);
            clear_graph();
            return;
        end
        for (int i = 0; i < top_vertex; i++) order[i] = i;
        for (int i = 1; i < top_vertex; i++)
        begin
            key = order[i];
            j = i;
            while (j > 0 && degree[order[j-1]] < degree[key])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        colored = '0;
        for (int k = 0; k < top_vertex; k++)
        begin
            v = order[k];
            used = '0;
            for (int i = 0; i < top_vertex; i++)
                if (colored[i] && adj_rows[v][i] && color_of[i] >= 1)
                    used[color_of[i]-1] = 1'b1;
            c = 1;
            while (c < 64 && used[c-1]) c++;
            color_of[v] = c[5:0];
            colored[v] = 1'b1;
            r.vertex = 6'(v + 1);
            r.color = c[5:0];
            r.last_vertex = (k + 1 == top_vertex);
            r.dropped = dropped_seen;
            r.empty = 1'b0;
            expected_colors.push_back(r);
        end
        clear_graph();
    endfunction

    initial
    begin
        fail_count = 0;
        clear_graph();
    end

    always @(posedge clk)
    begin
        coloring_t got;
        coloring_t exp_r;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_edge(s_axis_tdata[5:0], s_axis_tdata[11:6], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{vertex: m_axis_tdata[5:0], color: m_axis_tdata[11:6],
                        last_vertex: m_axis_tlast, dropped: m_axis_tuser[0],
                        empty: m_axis_tuser[1]};
                if (expected_colors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: %p", got);
                end
                else
                begin
                    exp_r = expected_colors.pop_front();
                    if (got !== exp_r || m_axis_tdata[15:12] !== 4'b0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, actual %p", exp_r, got);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the greedy_graph_coloring testbench: clock, reset, edge stimulus, verdict.
// Depends on ggc_pkg, greedy_graph_coloring and ggc_checker.
module tb_top;
    import ggc_pkg::*;

    localparam int MAXV = 32;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    bit          quiet_phase;
    bit          hold_sink;
    bit          stim_done;

    greedy_graph_coloring #(.MAX_VERTICES(MAXV)) i_dut (.*);

    ggc_checker #(.MAX_VERTICES(MAXV)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("CHECK FAILED");
        $finish;
    end

    // sink: random stalls, one long hold-off
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready = 1'b0;
                for (int i = 0; i < 3000; i++) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready = 1'b0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // valid stays high between back-to-back edges; the caller drops it at the end
    task automatic send_edge(int a, int b, bit last);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, b[5:0], a[5:0]};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int rand_vertex(int span);
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 63);
        return $urandom_range(1, span);
    endfunction

    initial
    begin
        int sent;
        int span;
        int len;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        // directed: empty graphs, dropped edges, self loop, repeats, extremes
        send_edge(0, 5, 1);
        send_edge(1, 2, 1);
        send_edge(33, 63, 0);
        send_edge(63, 0, 1);
        send_edge(3, 3, 0);
        send_edge(1, 2, 0);
        send_edge(1, 2, 0);
        send_edge(2, 3, 0);
        send_edge(0, 4, 0);
        send_edge(6, 6, 1);
        send_edge(32, 1, 0);
        send_edge(32, 31, 0);
        send_edge(31, 1, 1);
        // repeat edge 1-2 to raise both degrees; the 255 cap is not reached
        for (int i = 0; i < 130; i++) send_edge(1, 2, 0);
        send_edge(2, 3, 1);
        // triangle plus edge 4-5 while the sink is held off, filling the output
        hold_sink = 1'b1;
        send_edge(1, 2, 0);
        send_edge(2, 3, 0);
        send_edge(3, 1, 0);
        send_edge(4, 5, 1);
        send_edge(1, 4, 1);
        sent = 0;
        while (sent < 250)
        begin
            if (sent > 190) quiet_phase = 1'b1;
            span = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(2, 10);
            len = $urandom_range(1, 3 * span);
            for (int i = 0; i < len; i++)
            begin
                send_edge(rand_vertex(span), rand_vertex(span), i == len - 1);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (pending != 0 || hold_sink) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- greedy_graph_coloring.f -----
rtl/ggc_pkg.sv
rtl/ggc_ram.sv
rtl/greedy_graph_coloring.sv
tb/ggc_checker.sv
tb/tb_top.sv
